/* rtl/congestion_notice_generator_defines.svh */
// Assertion macros used by the congestion notice generator checker.
`ifndef CONGESTION_NOTICE_GENERATOR_DEFINES_SVH
`define CONGESTION_NOTICE_GENERATOR_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define CNG_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cng check failed");

// Next-cycle implication, ignored while reset is high.
`define CNG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cng check failed");

// Next-cycle implication that also covers reset.
`define CNG_ASSERT_NEXT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("cng check failed");

`endif

/* rtl/cng_pkg.sv */
// Package: sizes, codes and types of the congestion notice generator.
`timescale 1ns / 1ps
`default_nettype none
package cng_pkg;

  localparam int FLOW_SLOTS = 64;
  localparam int IDX_W      = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;
  localparam int CNT_W      = $clog2(FLOW_SLOTS + 1);

  localparam int S_TDATA_W  = 72;
  localparam int M_TDATA_W  = 136;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic OP_PACKET = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  localparam logic [1:0] ECN_CE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 8'd1;

  localparam logic [15:0] WINDOW_RESET = 16'd50;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage
`default_nettype wire

/* rtl/congestion_notice_generator.sv */
// Top level: congestion notice generator with a flow table in one RAM.
`timescale 1ns / 1ps
`default_nettype none
// Receiver-side congestion notice pacing. Each packet transaction on the
// slave stream carries a flow id, its ECN code and its source address; a
// tick transaction (tuser = 1) advances the notice window. When enabled and
// the packet is marked congestion experienced, the block counts the mark and,
// if the flow has had no notice in the current window, emits a notice toward
// the source and records the flow if room is left. Exactly one result transaction per input.
// Recorded flows live in a single-port-read RAM of FLOW_SLOTS words, filled
// in order; a fill count tells which words are live, so a window end clears
// the table by zeroing the count and no clearing pass is needed after reset.
// Ticks, unmarked packets, disabled packets and marked packets seen while the
// table is empty need no table lookup. A marked packet otherwise scans the
// table one word per cycle through the RAM read port, up to the last recorded
// flow; a match ends the scan early.
// A new item is taken while the previous result still sits in the
// output register; a result waits there until the master side takes it.
// Configuration: index 0 = receiver_enable, 1 = window_ticks; others ignored.
module congestion_notice_generator
  import cng_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // input stream
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // tdata, low bit up: flow_id[31:0], ecn_code[33:32], source_address[65:34], zero pad
  input  wire logic [S_TDATA_W-1:0]  s_tdata,
  // tuser: opcode[0]
  input  wire logic [0:0]            s_tuser,
  // result stream
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // tdata, low bit up: send_notice[0], notice_flow[32:1], notice_destination[64:33],
  // table_full[65], marked_total[97:66], notice_total[129:98], zero pad
  output logic [M_TDATA_W-1:0]       m_tdata,
  // configuration writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // ---------------------------------------------------------------- config
  logic        receiver_enable;
  logic [15:0] window_ticks;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      receiver_enable <= 1'b0;
      window_ticks    <= WINDOW_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ENABLE: receiver_enable <= cfg_data[0];
        CFG_WINDOW: window_ticks    <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- state
  state_t state, state_next;

  logic [CNT_W-1:0] used_count;
  logic [15:0]      tick_count;
  logic [31:0]      marked_count;
  logic [31:0]      notice_count;

  // latched item for the scan path
  logic        item_opcode;
  logic [31:0] item_flow;
  logic [1:0]  item_ecn;
  logic [31:0] item_src;
  logic        hit;

  // scan pointer: counts reads issued, can reach used_count itself
  logic [CNT_W-1:0] scan_idx;
  logic             rd_pending;
  logic [31:0]      rd_data;

  // flow table
  logic [31:0] flow_mem [FLOW_SLOTS];

  // input field view
  logic        in_opcode;
  logic [31:0] in_flow;
  logic [1:0]  in_ecn;
  logic [31:0] in_src;

  assign in_opcode = s_tuser[0];
  assign in_flow   = s_tdata[31:0];
  assign in_ecn    = s_tdata[33:32];
  assign in_src    = s_tdata[65:34];

  logic out_free;
  logic in_fast;
  logic hit_now;
  logic scan_done;

  assign out_free  = !m_tvalid || m_tready;
  // items that need no table lookup
  assign in_fast   = (in_opcode == OP_TICK) || !receiver_enable || (in_ecn != ECN_CE)
                     || (used_count == '0);
  assign hit_now   = rd_pending && (rd_data == item_flow);
  assign scan_done = (scan_idx == used_count) && !rd_pending;

  // ---------------------------------------------------------------- FSM
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (in_fast) state_next = out_free ? ST_IDLE : ST_FINISH;
          else         state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit_now || scan_done) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  logic accept;
  logic finish;
  logic rd_issue;

  always_comb begin
    s_tready = 1'b0;
    finish   = 1'b0;
    rd_issue = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        finish   = s_tvalid && in_fast && out_free;
      end
      ST_SCAN: begin
        rd_issue = (scan_idx < used_count) && !hit_now;
      end
      ST_FINISH: begin
        finish = out_free;
      end
      default: ;
    endcase
  end

  assign accept = s_tvalid && s_tready;

  // ---------------------------------------------------------------- result
  // In IDLE the result comes straight from the input; otherwise from the latch.
  logic        cur_opcode;
  logic [31:0] cur_flow;
  logic [1:0]  cur_ecn;
  logic [31:0] cur_src;
  logic        cur_hit;

  always_comb begin
    if (state == ST_IDLE) begin
      cur_opcode = in_opcode;
      cur_flow   = in_flow;
      cur_ecn    = in_ecn;
      cur_src    = in_src;
      cur_hit    = 1'b0;
    end else begin
      cur_opcode = item_opcode;
      cur_flow   = item_flow;
      cur_ecn    = item_ecn;
      cur_src    = item_src;
      cur_hit    = hit;
    end
  end

  logic        is_tick;
  logic        is_marked;
  logic        new_flow;
  logic        has_room;
  logic [15:0] tick_inc;
  logic        window_end;

  logic [CNT_W-1:0] used_count_next;
  logic [15:0]      tick_count_next;
  logic [31:0]      marked_count_next;
  logic [31:0]      notice_count_next;

  assign is_tick    = (cur_opcode == OP_TICK);
  assign is_marked  = !is_tick && receiver_enable && (cur_ecn == ECN_CE);
  assign new_flow   = is_marked && !cur_hit;
  assign has_room   = (used_count < CNT_W'(FLOW_SLOTS));
  assign tick_inc   = tick_count + 16'd1;
  // a zero window length acts as one; lowering it below the count ends on the next tick
  assign window_end = (tick_inc >= window_ticks) || (tick_inc == 16'd0);

  always_comb begin
    used_count_next   = used_count;
    tick_count_next   = tick_count;
    marked_count_next = marked_count;
    notice_count_next = notice_count;
    if (is_tick) begin
      tick_count_next = window_end ? 16'd0 : tick_inc;
      if (window_end) used_count_next = '0;
    end else if (is_marked) begin
      marked_count_next = marked_count + 32'd1;
      if (new_flow) begin
        notice_count_next = notice_count + 32'd1;
        if (has_room) used_count_next = used_count + CNT_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      used_count   <= '0;
      tick_count   <= '0;
      marked_count <= '0;
      notice_count <= '0;
      hit          <= 1'b0;
      scan_idx     <= '0;
      rd_pending   <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      state      <= state_next;
      rd_pending <= rd_issue;
      if (accept) begin
        hit      <= 1'b0;
        scan_idx <= '0;
      end else begin
        if (state == ST_SCAN && hit_now) hit <= 1'b1;
        if (rd_issue) scan_idx <= scan_idx + CNT_W'(1);
      end
      if (finish) begin
        used_count   <= used_count_next;
        tick_count   <= tick_count_next;
        marked_count <= marked_count_next;
        notice_count <= notice_count_next;
        m_tvalid     <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // item latch and output payload
  always_ff @(posedge clk) begin
    if (accept) begin
      item_opcode <= in_opcode;
      item_flow   <= in_flow;
      item_ecn    <= in_ecn;
      item_src    <= in_src;
    end
    if (finish) begin
      m_tdata <= {6'd0,
                  notice_count_next,
                  marked_count_next,
                  new_flow && !has_room,
                  new_flow ? cur_src : 32'd0,
                  new_flow ? cur_flow : 32'd0,
                  new_flow};
    end
  end

  // flow table: new flows go to the next free word, reads are registered
  always_ff @(posedge clk) begin
    if (finish && new_flow && has_room) begin
      flow_mem[used_count[IDX_W-1:0]] <= cur_flow;
    end
    if (rd_issue) begin
      rd_data <= flow_mem[scan_idx[IDX_W-1:0]];
    end
  end

endmodule
`default_nettype wire

/* rtl/cng_checker.sv */
// Port checker for the congestion notice generator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "congestion_notice_generator_defines.svh"
module cng_checker
  import cng_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  m_tvalid,
  input wire logic                  m_tready,
  input wire logic [M_TDATA_W-1:0]  m_tdata
);

  // no notice means empty notice fields
  `CNG_ASSERT_IMPL(a_quiet_fields, m_tvalid && !m_tdata[0], m_tdata[65:1] == 65'd0)

  // table full is only reported with a notice
  `CNG_ASSERT_IMPL(a_full_with_notice, m_tvalid && m_tdata[65], m_tdata[0])

  // a stalled result stays offered
  `CNG_ASSERT_NEXT(a_result_held, m_tvalid && !m_tready, m_tvalid)

  // reset empties the output register
  `CNG_ASSERT_NEXT_RST(a_reset_clears, rst, !m_tvalid)

endmodule

bind congestion_notice_generator cng_checker u_cng_checker (.*);
`default_nettype wire

/* bench/tb_congestion_notice_generator.sv */
// Testbench for the congestion notice generator: directed table, table fill, random phases.
`timescale 1ns / 1ps
module tb_congestion_notice_generator;
  import cng_pkg::*;

  // ECN codepoints other than congestion experienced
  localparam logic [1:0] ECN_NOT_ECT = 2'd0;
  localparam logic [1:0] ECN_ECT1    = 2'd1;
  localparam logic [1:0] ECN_ECT0    = 2'd2;

  // register indexes that must be ignored by the block
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP    = 8'hFF;

  localparam int QUIET_LIMIT = 4000;          // cycles with no transaction at all
  localparam int TAIL_CYCLES = FLOW_SLOTS + 16; // drain after the last result
  localparam int PHASES      = 8;

  // result layout, first member sits in the top bits of m_tdata[129:0]
  typedef struct packed {
    logic [31:0] notices;
    logic [31:0] marked;
    logic        full;
    logic [31:0] dest;
    logic [31:0] flow;
    logic        send;
  } notice_t;

  typedef enum logic [1:0] {
    ROW_PKT,
    ROW_TICK,
    ROW_CFG
  } row_kind_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_t;

  // one line of the directed table; a/b are flow/source or index/data
  typedef struct {
    row_kind_t   kind;
    logic [31:0] a;
    logic [1:0]  ecn;
    logic [31:0] b;
    bit          chk;
    notice_t     want;
  } dir_row_t;

  // typed-in expectation that travels with an issued transaction
  typedef struct {
    bit      typed;
    notice_t want;
  } issue_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  wire logic             s_tready;
  logic [S_TDATA_W-1:0]  s_tdata = '0;
  logic [0:0]            s_tuser = '0;
  wire logic             m_tvalid;
  logic                  m_tready = 1'b0;
  wire logic [M_TDATA_W-1:0] m_tdata;
  logic                  cfg_valid = 1'b0;
  wire logic             cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  congestion_notice_generator u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),   // flow_id[31:0], ecn_code[33:32], source_address[65:34]
    .s_tuser   (s_tuser),   // opcode[0]
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),   // send[0], flow[32:1], dest[64:33], full[65], marked, notices
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Notice predictor: own copy of registers and flow table.
  // Slots fill in order and a window end frees all of them, so the live
  // table is always the prefix [0, used_cnt).
  // ---------------------------------------------------------------------------
  logic        rx_enable  = 1'b0;
  logic [15:0] win_len    = WINDOW_RESET;
  logic [31:0] flow_tab [FLOW_SLOTS];
  int          used_cnt   = 0;
  logic [15:0] tick_cnt   = '0;
  logic [31:0] marked_cnt = '0;
  logic [31:0] notice_cnt = '0;

  function automatic notice_t predict_notice(logic op, logic [31:0] flow, logic [1:0] ecn,
                                             logic [31:0] src);
    notice_t r;
    bit      hit;
    int      i;
    r   = '0;
    hit = 1'b0;
    if (op == OP_TICK) begin
      tick_cnt = tick_cnt + 16'd1;
      // zero window acts as one; 16-bit wrap also closes the window
      if (tick_cnt >= win_len || tick_cnt == 16'd0) begin
        used_cnt = 0;
        tick_cnt = '0;
      end
    end else if (rx_enable && ecn == ECN_CE) begin
      for (i = 0; i < used_cnt; i++)
        if (flow_tab[i] == flow) hit = 1'b1;
      if (!hit) begin
        r.send = 1'b1;
        r.flow = flow;
        r.dest = src;
        if (used_cnt < FLOW_SLOTS) begin
          flow_tab[used_cnt] = flow;
          used_cnt++;
        end else begin
          r.full = 1'b1;   // table full: notice still goes out, flow not kept
        end
        notice_cnt = notice_cnt + 32'd1;
      end
      marked_cnt = marked_cnt + 32'd1;
    end
    r.marked  = marked_cnt;
    r.notices = notice_cnt;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard
  // ---------------------------------------------------------------------------
  notice_t  notice_q[$];   // expected notices, oldest first
  issue_t   issue_q[$];    // per issued transaction: typed-in expectation or not
  int       sent_count    = 0;
  int       checked_count = 0;
  int       fail_count    = 0;
  notice_t  result_got;
  notice_t  result_want;
  notice_t  result_pred;
  issue_t   issue_head;

  always @(posedge clk) begin
    if (!rst) begin
      // result side first: a result never belongs to an input taken on the same edge
      if (m_tvalid && m_tready) begin
        result_got = m_tdata[$bits(notice_t)-1:0];
        if (notice_q.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: result transaction with no notice expected", $realtime);
          fail_count++;
        end else begin
          result_want = notice_q.pop_front();
          if (result_got.send !== result_want.send || result_got.flow !== result_want.flow ||
              result_got.dest !== result_want.dest || result_got.full !== result_want.full ||
              result_got.marked !== result_want.marked ||
              result_got.notices !== result_want.notices) begin
            if (fail_count < 10) begin
              $display("%0t: want send=%0b flow=%h dest=%h full=%0b marked=%0d notices=%0d",
                       $realtime, result_want.send, result_want.flow, result_want.dest,
                       result_want.full, result_want.marked, result_want.notices);
              $display("%0t:  got send=%0b flow=%h dest=%h full=%0b marked=%0d notices=%0d",
                       $realtime, result_got.send, result_got.flow, result_got.dest,
                       result_got.full, result_got.marked, result_got.notices);
            end
            fail_count++;
          end
        end
        checked_count++;
      end
      // input side: predictor always runs so its state tracks the block
      if (s_tvalid && s_tready) begin
        issue_head  = issue_q.pop_front();
        result_pred = predict_notice(s_tuser[0], s_tdata[31:0], s_tdata[33:32],
                                     s_tdata[65:34]);
        notice_q.push_back(issue_head.typed ? issue_head.want : result_pred);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern that switches at random among four ready modes
  // ---------------------------------------------------------------------------
  rx_mode_t rx_mode   = RX_OPEN;
  int       rx_left   = 0;
  int       cyc_count = 0;

  always @(posedge clk) begin
    cyc_count <= cyc_count + 1;
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(16, 160);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   m_tready <= 1'b1;
      RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
      default:   m_tready <= (cyc_count[2:0] < 3'd5);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Watchdog: any transaction on any channel resets the quiet count
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("%0t: no transaction for %0d cycles", $realtime, QUIET_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sender helpers
  // ---------------------------------------------------------------------------
  int burst_left = 0;

  // gap after the current transaction: zero inside a burst, random between bursts
  function automatic int next_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(80, 250) : $urandom_range(0, 20);
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 15);
    return $urandom_range(16, 40);
  endfunction

  // called on a rising edge; returns on a rising edge
  task automatic drive_item(input logic op, input logic [31:0] flow, input logic [1:0] ecn,
                            input logic [31:0] src, input bit typed, input notice_t want,
                            input int gap);
    issue_t it;
    it.typed = typed;
    it.want  = want;
    issue_q.push_back(it);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {{(S_TDATA_W-66){1'b0}}, src, ecn, flow};
    do @(posedge clk); while (s_tready !== 1'b1);
    sent_count++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drop valid and wait until every issued transaction has its result back
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (checked_count < sent_count) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx == CFG_ENABLE)
      rx_enable = val[0];
    else if (idx == CFG_WINDOW)
      win_len = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  dir_row_t dir_rows[$];

  function automatic void add_row(row_kind_t kind, logic [31:0] a, logic [1:0] ecn,
                                  logic [31:0] b, bit chk, logic send, logic [31:0] marked,
                                  logic [31:0] notices);
    dir_row_t r;
    r.kind         = kind;
    r.a            = a;
    r.ecn          = ecn;
    r.b            = b;
    r.chk          = chk;
    r.want         = '0;
    r.want.send    = send;
    r.want.flow    = send ? a : 32'd0;
    r.want.dest    = send ? b : 32'd0;
    r.want.marked  = marked;
    r.want.notices = notices;
    dir_rows.push_back(r);
  endfunction

  // random phases: one register setting and traffic mix each
  logic [15:0] ph_enable [PHASES] = '{16'h0001, 16'h0003, 16'h0001, 16'hFFFE,
                                      16'h0001, 16'hFFFF, 16'h0001, 16'h0001};
  logic [15:0] ph_window [PHASES] = '{16'd50, 16'd1, 16'hFFFF, 16'd5,
                                      16'd3, 16'd0, 16'd200, 16'd12};
  int          ph_tick   [PHASES] = '{10, 20, 2, 15, 25, 10, 5, 12};   // tick percentage
  int          ph_pool   [PHASES] = '{48, 16, 96, 32, 24, 16, 80, 40}; // distinct flows
  int          ph_items  [PHASES] = '{250, 150, 300, 100, 200, 100, 250, 200};
  logic [31:0] flow_pool [96];

  initial begin
    int          i;
    int          p;
    int          n;
    int          pick;
    logic        op;
    logic [31:0] flow;
    logic [1:0]  ecn;
    logic [31:0] src;
    logic [31:0] fill_base;

    // after reset: disabled, window 50
    add_row(ROW_PKT,  32'h0000_0011, ECN_CE,      32'h0A00_0001, 1, 0, 0, 0);
    add_row(ROW_TICK, 32'hFFFF_FFFF, ECN_CE,      32'hFFFF_FFFF, 1, 0, 0, 0); // fields ignored
    add_row(ROW_CFG,  CFG_ENABLE,    ECN_NOT_ECT, 32'd1,         0, 0, 0, 0);
    // unmarked codepoints: nothing counted
    add_row(ROW_PKT,  32'hFFFF_FFFF, ECN_NOT_ECT, 32'hFFFF_FFFF, 1, 0, 0, 0);
    add_row(ROW_PKT,  32'h5555_5555, ECN_ECT1,    32'hAAAA_AAAA, 1, 0, 0, 0);
    add_row(ROW_PKT,  32'hAAAA_AAAA, ECN_ECT0,    32'h5555_5555, 1, 0, 0, 0);
    // first mark of a flow sends, repeats in the window only count
    add_row(ROW_PKT,  32'h0000_0000, ECN_CE,      32'h0000_0000, 1, 1, 1, 1);
    add_row(ROW_PKT,  32'hFFFF_FFFF, ECN_CE,      32'hFFFF_FFFF, 1, 1, 2, 2);
    add_row(ROW_PKT,  32'h0000_0000, ECN_CE,      32'h1234_5678, 0, 0, 0, 0);
    add_row(ROW_PKT,  32'hFFFF_FFFF, ECN_CE,      32'h0000_0000, 0, 0, 0, 0);
    // window of two; one tick is already pending, so the next tick closes it
    add_row(ROW_CFG,  CFG_WINDOW,    ECN_NOT_ECT, 32'd2,         0, 0, 0, 0);
    add_row(ROW_TICK, 32'd0,         ECN_NOT_ECT, 32'd0,         1, 0, 4, 2);
    add_row(ROW_PKT,  32'h0000_0000, ECN_CE,      32'hC0A8_0001, 1, 1, 5, 3);
    add_row(ROW_TICK, 32'd0,         ECN_NOT_ECT, 32'd0,         1, 0, 5, 3);
    add_row(ROW_PKT,  32'h0000_0000, ECN_CE,      32'hC0A8_0002, 1, 0, 6, 3);
    add_row(ROW_TICK, 32'd0,         ECN_NOT_ECT, 32'd0,         1, 0, 6, 3);
    add_row(ROW_PKT,  32'h0000_0000, ECN_CE,      32'h7F00_0001, 1, 1, 7, 4);
    // zero window behaves as a window of one
    add_row(ROW_CFG,  CFG_WINDOW,    ECN_NOT_ECT, 32'd0,         0, 0, 0, 0);
    add_row(ROW_TICK, 32'd0,         ECN_NOT_ECT, 32'd0,         1, 0, 7, 4);
    add_row(ROW_PKT,  32'h0000_0000, ECN_CE,      32'h0102_0304, 1, 1, 8, 5);
    // writes to indexes past the register list change nothing
    add_row(ROW_CFG,  CFG_UNUSED,    ECN_NOT_ECT, 32'hFFFF,      0, 0, 0, 0);
    add_row(ROW_CFG,  CFG_TOP,       ECN_NOT_ECT, 32'h0000,      0, 0, 0, 0);
    add_row(ROW_PKT,  32'h5A5A_5A5A, ECN_CE,      32'hA5A5_A5A5, 1, 1, 9, 6);
    // lowering the window below the running count ends it on the next tick
    add_row(ROW_CFG,  CFG_WINDOW,    ECN_NOT_ECT, 32'hFFFF,      0, 0, 0, 0);
    add_row(ROW_TICK, 32'd0,         ECN_NOT_ECT, 32'd0,         1, 0, 9, 6);
    add_row(ROW_TICK, 32'd0,         ECN_NOT_ECT, 32'd0,         1, 0, 9, 6);
    add_row(ROW_TICK, 32'd0,         ECN_NOT_ECT, 32'd0,         1, 0, 9, 6);
    add_row(ROW_PKT,  32'h5A5A_5A5A, ECN_CE,      32'h0BAD_F00D, 1, 0, 10, 6);
    add_row(ROW_CFG,  CFG_WINDOW,    ECN_NOT_ECT, 32'd2,         0, 0, 0, 0);
    add_row(ROW_TICK, 32'd0,         ECN_NOT_ECT, 32'd0,         1, 0, 10, 6);
    add_row(ROW_PKT,  32'h5A5A_5A5A, ECN_CE,      32'hDEAD_BEEF, 1, 1, 11, 7);
    // only bit 0 of the enable register counts
    add_row(ROW_CFG,  CFG_ENABLE,    ECN_NOT_ECT, 32'hFFFE,      0, 0, 0, 0);
    add_row(ROW_PKT,  32'h5A5A_5A5A, ECN_CE,      32'h0000_0001, 1, 0, 11, 7);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[d]) begin
      if (dir_rows[d].kind == ROW_CFG) begin
        wait_idle();
        write_reg(dir_rows[d].a[CFG_IDX_W-1:0], dir_rows[d].b[CFG_DATA_W-1:0]);
      end else begin
        drive_item(dir_rows[d].kind == ROW_TICK ? OP_TICK : OP_PACKET, dir_rows[d].a,
                   dir_rows[d].ecn, dir_rows[d].b, dir_rows[d].chk, dir_rows[d].want,
                   $urandom_range(0, 2));
      end
    end

    // table fill: every slot taken, the last two new flows find the table full,
    // a recorded flow still matches, and a tick does not close the long window
    wait_idle();
    write_reg(CFG_ENABLE, 16'd1);
    write_reg(CFG_WINDOW, 16'hFFFF);
    fill_base = $urandom & 32'hFFFF_FF00;
    for (i = 0; i <= FLOW_SLOTS; i++)
      drive_item(OP_PACKET, fill_base | i, ECN_CE, $urandom, 1'b0, '0, next_gap());
    drive_item(OP_PACKET, fill_base | 32'd3, ECN_CE, $urandom, 1'b0, '0, next_gap());
    drive_item(OP_TICK, $urandom, ECN_CE, $urandom, 1'b0, '0, next_gap());
    drive_item(OP_PACKET, fill_base | 32'd7, ECN_CE, $urandom, 1'b0, '0, next_gap());

    // random phases: mostly marked packets from a small flow pool so that
    // repeats, window ends and full tables all come up; the rest is noise
    for (p = 0; p < PHASES; p++) begin
      wait_idle();
      write_reg(CFG_ENABLE, ph_enable[p]);
      write_reg(CFG_WINDOW, ph_window[p]);
      for (i = 0; i < ph_pool[p]; i++)
        flow_pool[i] = $urandom;
      for (n = 0; n < ph_items[p]; n++) begin
        pick = $urandom_range(0, 99);
        op   = OP_PACKET;
        flow = flow_pool[$urandom_range(0, ph_pool[p] - 1)];
        ecn  = ECN_CE;
        src  = $urandom;
        if (pick < ph_tick[p]) begin
          op   = OP_TICK;
          flow = $urandom;
          ecn  = 2'($urandom_range(0, 3));
        end else if (pick < ph_tick[p] + 60) begin
          // marked packet of a pooled flow
        end else if (pick < ph_tick[p] + 75) begin
          ecn = 2'($urandom_range(0, 2));
        end else if (pick < ph_tick[p] + 85) begin
          flow = $urandom;
        end else begin
          flow = $urandom;
          ecn  = 2'($urandom_range(0, 3));
        end
        drive_item(op, flow, ecn, src, 1'b0, '0, next_gap());
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (notice_q.size() != 0) begin
      $display("%0t: %0d notices never arrived", $realtime, notice_q.size());
      fail_count++;
    end
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/cng_pkg.sv
rtl/congestion_notice_generator.sv
rtl/cng_checker.sv
bench/tb_congestion_notice_generator.sv
